/* hdl/r2fft_pkg.sv */
// Shared types and constants for the radix-2 FFT block.
// Command encoding between controller and datapath, request codes, register map.
// No dependencies.
package r2fft_pkg;

    localparam int DW         = 40;  // internal data word
    localparam int OW         = 32;  // read result width
    localparam int ADDR_MAXW  = 16;  // widest point address the command carries
    localparam int SHAMT_W    = 5;   // holds log2 of the largest size
    localparam int FUNC_W     = 2;
    localparam int INDEX_W    = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RUN   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_INVERSE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOG2    = 1'd1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_WRITE,   // store captured sample at addr_a
        OP_FETCH,   // read addr_a, addr_b and twiddle tw
        OP_MUL,     // twiddle products
        OP_SUM,     // rounded complex product
        OP_WR_P,    // addr_a <= a + y
        OP_WR_Q,    // addr_b <= a - y
        OP_SWAP_A,  // addr_a <= fetched b
        OP_SWAP_B,  // addr_b <= fetched a
        OP_SCALE,   // addr_a <= fetched a >> shamt, rounded
        OP_OUT,     // load read result
        OP_DONE,    // load run result
        OP_CLEAR    // clear sticky flag
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [ADDR_MAXW-1:0] addr_a;
        logic [ADDR_MAXW-1:0] addr_b;
        logic [ADDR_MAXW-1:0] tw;
        logic [SHAMT_W-1:0]   shamt;
        logic                 inv;
    } t_cmd;

endpackage

/* hdl/r2fft_ifs.sv */
// Valid/ready channel interfaces of the FFT block: requests, results, register writes.
// Depends on r2fft_pkg.
interface r2fft_in_if #(parameter int SB = 24);
    logic                                   valid;
    logic                                   ready;
    logic [r2fft_pkg::FUNC_W-1:0]           func;
    logic [r2fft_pkg::INDEX_W-1:0]          index;
    logic signed [SB-1:0]                   re_in;
    logic signed [SB-1:0]                   im_in;
    modport source (output valid, func, index, re_in, im_in, input ready);
    modport sink   (input valid, func, index, re_in, im_in, output ready);
endinterface

interface r2fft_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [r2fft_pkg::OW-1:0] re_out;
    logic signed [r2fft_pkg::OW-1:0] im_out;
    logic                            saturated;
    modport source (output valid, re_out, im_out, saturated, input ready);
    modport sink   (input valid, re_out, im_out, saturated, output ready);
endinterface

interface r2fft_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [r2fft_pkg::CFG_IDX_W-1:0]    index;
    logic [r2fft_pkg::CFG_DATA_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/radix2_complex_fft.sv */
// In-place radix-2 DIT complex FFT. A write request stores its sample; a read fetches the
// point, then loads the result once the result slot is free. A run does bit reversal, then
// butterflies of fetch, multiply, sum, write P, write Q (one shared multiply path, one memory
// write port), scaling in inverse mode, then the done result; one request at a time.
// Reset clears control, the sticky flag, inverse_mode (0) and log2_size (10); point memory
// is not cleared and is undefined until written.
module radix2_complex_fft #(
    parameter int MAX_POINTS   = 1024,
    parameter int SAMPLE_BITS  = 24,
    parameter int TWIDDLE_BITS = 18
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    r2fft_in_if.sink          i_in,
    r2fft_out_if.source       o_out,
    r2fft_cfg_if.sink         i_cfg
);
    import r2fft_pkg::*;

    t_cmd cmd;

    r2fft_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_func      (i_in.func),
        .i_index     (i_in.index),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_cfg_valid (i_cfg.valid),
        .o_cfg_ready (i_cfg.ready),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_cmd       (cmd)
    );

    r2fft_dp #(
        .MAX_POINTS   (MAX_POINTS),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .TWIDDLE_BITS (TWIDDLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_re_in     (i_in.re_in),
        .i_im_in     (i_in.im_in),
        .o_re_out    (o_out.re_out),
        .o_im_out    (o_out.im_out),
        .o_saturated (o_out.saturated)
    );

endmodule

/* hdl/r2fft_ctrl.sv */
// Sequencer of the FFT: request intake, register file, bit-reverse, butterfly
// and scaling address generation, result handshake. Depends on r2fft_pkg.
module r2fft_ctrl #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [r2fft_pkg::FUNC_W-1:0]        i_func,
    input  logic [r2fft_pkg::INDEX_W-1:0]       i_index,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [r2fft_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [r2fft_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output r2fft_pkg::t_cmd                     o_cmd
);
    import r2fft_pkg::*;

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int TAW = (AW > 1) ? AW - 1 : 1;
    localparam int LW  = $clog2(AW + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_BR, S_BR_SA, S_BR_SB,
        S_BF_FETCH, S_BF_MUL, S_BF_SUM, S_BF_WP, S_BF_WQ,
        S_SC_FETCH, S_SC_WR, S_FIN
    } t_state;

    t_state                 r_state, n_state;
    t_cmd                   r_cmd, n_cmd;
    logic                   r_out_valid, n_out_valid;
    logic                   r_inv;
    logic [CFG_DATA_W-1:0]  r_log2;
    logic [LW-1:0]          r_l, n_l;
    logic [AW-1:0]          r_i, n_i;
    logic [TAW-1:0]         r_c, n_c;
    logic [LW-1:0]          r_s, n_s;

    logic [LW-1:0]          leff;
    logic [AW:0]            n_full;
    logic [AW-1:0]          nmask;
    logic [TAW-1:0]         cmask;
    logic [AW-1:0]          mask_s, cz, addr_p, addr_q, tw_full, rev_full, rv;
    logic [LW-1:0]          tsh;
    logic                   slot_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = r_cmd;
    assign slot_free   = !r_out_valid || i_out_ready;

    assign leff   = (int'(r_log2) > AW) ? LW'(AW) : LW'(r_log2);
    assign n_full = ((AW + 1)'(1) << r_l) - (AW + 1)'(1);
    assign nmask  = n_full[AW-1:0];
    assign cmask  = TAW'(nmask >> 1);

    // butterfly pair: insert a zero at bit s of the counter
    assign mask_s  = (AW'(1) << r_s) - AW'(1);
    assign cz      = AW'(r_c);
    assign addr_p  = ((cz & ~mask_s) << 1) | (cz & mask_s);
    assign addr_q  = addr_p | (AW'(1) << r_s);
    assign tsh     = LW'(AW - 1) - r_s;
    assign tw_full = (cz & mask_s) << tsh;

    always_comb begin
        for (int b = 0; b < AW; b++) begin
            rev_full[AW-1-b] = r_i[b];
        end
    end
    assign rv = rev_full >> (LW'(AW) - r_l);

    always_comb begin
        n_state     = r_state;
        n_cmd       = '0;
        n_cmd.op    = OP_NONE;
        n_cmd.inv   = r_inv;
        n_cmd.shamt = SHAMT_W'(r_l);
        n_l         = r_l;
        n_i         = r_i;
        n_c         = r_c;
        n_s         = r_s;
        if (r_cmd.op == OP_OUT || r_cmd.op == OP_DONE) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd.addr_a = ADDR_MAXW'(AW'(i_index));
                    case (i_func)
                        FUNC_WRITE: n_cmd.op = OP_WRITE;
                        FUNC_READ: begin
                            n_cmd.op = OP_FETCH;
                            n_state  = S_RD;
                        end
                        FUNC_RUN: begin
                            n_cmd.op = OP_CLEAR;
                            n_l      = leff;
                            n_i      = '0;
                            n_state  = (leff == '0) ? S_FIN : S_BR;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD: begin
                if (slot_free) begin
                    n_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            S_BR, S_BR_SA, S_BR_SB: begin
                n_cmd.addr_a = ADDR_MAXW'(r_i);
                n_cmd.addr_b = ADDR_MAXW'(rv);
                if (r_state == S_BR && r_i < rv) begin
                    n_cmd.op = OP_FETCH;
                    n_state  = S_BR_SA;
                end else if (r_state == S_BR_SA) begin
                    n_cmd.op = OP_SWAP_A;
                    n_state  = S_BR_SB;
                end else begin
                    if (r_state == S_BR_SB) begin
                        n_cmd.op = OP_SWAP_B;
                    end
                    if (r_i == nmask) begin
                        n_c     = '0;
                        n_s     = '0;
                        n_state = S_BF_FETCH;
                    end else begin
                        n_i     = r_i + AW'(1);
                        n_state = S_BR;
                    end
                end
            end
            S_BF_FETCH, S_BF_MUL, S_BF_SUM, S_BF_WP, S_BF_WQ: begin
                n_cmd.addr_a = ADDR_MAXW'(addr_p);
                n_cmd.addr_b = ADDR_MAXW'(addr_q);
                n_cmd.tw     = ADDR_MAXW'(TAW'(tw_full));
                case (r_state)
                    S_BF_FETCH: begin
                        n_cmd.op = OP_FETCH;
                        n_state  = S_BF_MUL;
                    end
                    S_BF_MUL: begin
                        n_cmd.op = OP_MUL;
                        n_state  = S_BF_SUM;
                    end
                    S_BF_SUM: begin
                        n_cmd.op = OP_SUM;
                        n_state  = S_BF_WP;
                    end
                    S_BF_WP: begin
                        n_cmd.op = OP_WR_P;
                        n_state  = S_BF_WQ;
                    end
                    default: begin
                        n_cmd.op = OP_WR_Q;
                        n_state  = S_BF_FETCH;
                        if (r_c == cmask) begin
                            n_c = '0;
                            if (r_s == r_l - LW'(1)) begin
                                n_i     = '0;
                                n_state = r_inv ? S_SC_FETCH : S_FIN;
                            end else begin
                                n_s = r_s + LW'(1);
                            end
                        end else begin
                            n_c = r_c + TAW'(1);
                        end
                    end
                endcase
            end
            S_SC_FETCH: begin
                n_cmd.op     = OP_FETCH;
                n_cmd.addr_a = ADDR_MAXW'(r_i);
                n_state      = S_SC_WR;
            end
            S_SC_WR: begin
                n_cmd.op     = OP_SCALE;
                n_cmd.addr_a = ADDR_MAXW'(r_i);
                if (r_i == nmask) begin
                    n_state = S_FIN;
                end else begin
                    n_i     = r_i + AW'(1);
                    n_state = S_SC_FETCH;
                end
            end
            S_FIN: begin
                if (slot_free) begin
                    n_cmd.op = OP_DONE;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmd       <= '0;
            r_out_valid <= 1'b0;
            r_inv       <= 1'b0;
            r_log2      <= CFG_DATA_W'(10);
            r_l         <= '0;
            r_i         <= '0;
            r_c         <= '0;
            r_s         <= '0;
        end else begin
            r_state     <= n_state;
            r_cmd       <= n_cmd;
            r_out_valid <= n_out_valid;
            r_l         <= n_l;
            r_i         <= n_i;
            r_c         <= n_c;
            r_s         <= n_s;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_INVERSE: r_inv  <= i_cfg_data[0];
                    REG_LOG2:    r_log2 <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // result register is never loaded while it still holds an undelivered result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cmd.op == OP_OUT || r_cmd.op == OP_DONE) |-> !r_out_valid)
        else $error("result overwritten");

    a_pass_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BF_FETCH) |-> (r_s < r_l))
        else $error("butterfly pass beyond size");

    a_swap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BR_SA) |-> (r_cmd.op == OP_FETCH && r_cmd.addr_a < r_cmd.addr_b))
        else $error("bit-reverse swap issued twice");

endmodule

/* hdl/r2fft_dp.sv */
// Datapath of the FFT: point memory, twiddle ROM, butterfly arithmetic,
// inverse scaling, saturation and result register. Depends on r2fft_pkg.
module r2fft_dp #(
    parameter int MAX_POINTS   = 1024,
    parameter int SAMPLE_BITS  = 24,
    parameter int TWIDDLE_BITS = 18
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  r2fft_pkg::t_cmd                 i_cmd,
    input  logic signed [SAMPLE_BITS-1:0]   i_re_in,
    input  logic signed [SAMPLE_BITS-1:0]   i_im_in,
    output logic signed [r2fft_pkg::OW-1:0] o_re_out,
    output logic signed [r2fft_pkg::OW-1:0] o_im_out,
    output logic                            o_saturated
);
    import r2fft_pkg::*;

    localparam int AW      = $clog2(MAX_POINTS);
    localparam int TAW     = (AW > 1) ? AW - 1 : 1;
    localparam int HALF    = MAX_POINTS / 2;
    localparam int QUARTER = MAX_POINTS / 4;
    localparam int TWB     = TWIDDLE_BITS;
    localparam int F       = TWB - 1;
    localparam int PW      = DW + TWB;
    localparam int SW      = PW + 2;
    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
    localparam logic signed [SW-1:0] RND = SW'(1 << (F - 1));

    // long division by compare and subtract, only evaluated while building the ROM
    function automatic longint unsigned udiv_elab(input longint unsigned num,
                                                  input longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem  = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Taylor series in Q30, each term truncated; returns {cos, sin}
    function automatic logic [127:0] trig_q30(input longint unsigned x);
        longint unsigned term;
        longint          ca;
        longint          sa;
        term = 64'd1 << 30;
        ca   = longint'(term);
        sa   = 0;
        for (int n = 1; n <= 18; n++) begin
            term = udiv_elab((term * x) >> 30, 64'(n));
            case (n & 3)
                1:       sa = sa + longint'(term);
                2:       ca = ca - longint'(term);
                3:       sa = sa - longint'(term);
                default: ca = ca + longint'(term);
            endcase
        end
        return {ca, sa};
    endfunction

    function automatic logic signed [TWB-1:0] q30_to_tw(input longint acc);
        longint unsigned mag;
        longint unsigned r;
        longint unsigned lim;
        mag = (acc < 0) ? longint'(-acc) : longint'(acc);
        lim = (64'd1 << F) - 64'd1;
        r   = (mag + (64'd1 << (29 - F))) >> (30 - F);
        if (r > lim) r = lim;
        return (acc < 0) ? -TWB'(r) : TWB'(r);
    endfunction

    logic signed [TWB-1:0] rom_cos [HALF];
    logic signed [TWB-1:0] rom_sin [HALF];

    for (genvar k = 0; k < HALF; k++) begin : g_rom
        localparam longint unsigned KK = (k <= QUARTER) ? k : HALF - k;
        localparam longint unsigned X  = (KK * TWO_PI_Q30) / MAX_POINTS;
        localparam logic [127:0] CS = trig_q30(X);
        localparam logic signed [TWB-1:0] TC = q30_to_tw(longint'(CS[127:64]));
        localparam logic signed [TWB-1:0] TS = q30_to_tw(longint'(CS[63:0]));
        assign rom_cos[k] = (k <= QUARTER) ? TC : -TC;
        assign rom_sin[k] = TS;
    end

    logic [2*DW-1:0]        r_mem [MAX_POINTS];
    logic [2*DW-1:0]        r_smp;
    logic [2*DW-1:0]        r_rd_a, r_rd_b;
    logic signed [TWB-1:0]  r_tw_c, r_tw_s;
    logic signed [PW-1:0]   r_p_rr, r_p_ii, r_p_ri, r_p_ir;
    logic signed [SW-1:0]   r_yr, r_yi;
    logic signed [OW-1:0]   r_out_re, r_out_im;
    logic                   r_out_sat;
    logic                   r_sticky;

    logic signed [DW-1:0]   a_re, a_im, b_re, b_im;
    logic signed [SW-1:0]   d_re, d_im;
    logic signed [SW:0]     s_pr, s_pi, s_qr, s_qi;
    logic signed [DW-1:0]   w_pr, w_pi, w_qr, w_qi;
    logic                   h_pr, h_pi, h_qr, h_qi;
    logic signed [DW:0]     rnd_sc, sc_re, sc_im;
    logic signed [OW-1:0]   o32_re, o32_im;
    logic                   h32_re, h32_im;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [2*DW-1:0]        wr_data;
    logic [AW-1:0]          addr_a, addr_b;
    logic [TAW-1:0]         tw_idx;

    function automatic logic [DW:0] sat_w(input logic signed [SW:0] v);
        logic hit;
        hit = !(&v[SW:DW-1] || ~|v[SW:DW-1]);
        if (!hit) return {1'b0, v[DW-1:0]};
        return {1'b1, v[SW], {(DW-1){~v[SW]}}};
    endfunction

    function automatic logic [OW:0] sat_o(input logic signed [DW-1:0] v);
        logic hit;
        hit = !(&v[DW-1:OW-1] || ~|v[DW-1:OW-1]);
        if (!hit) return {1'b0, v[OW-1:0]};
        return {1'b1, v[DW-1], {(OW-1){~v[DW-1]}}};
    endfunction

    assign addr_a = i_cmd.addr_a[AW-1:0];
    assign addr_b = i_cmd.addr_b[AW-1:0];
    assign tw_idx = i_cmd.tw[TAW-1:0];

    assign a_re = r_rd_a[2*DW-1:DW];
    assign a_im = r_rd_a[DW-1:0];
    assign b_re = r_rd_b[2*DW-1:DW];
    assign b_im = r_rd_b[DW-1:0];

    assign d_re = SW'(r_p_rr) - SW'(r_p_ii) + RND;
    assign d_im = SW'(r_p_ri) + SW'(r_p_ir) + RND;

    assign s_pr = (SW + 1)'(a_re) + (SW + 1)'(r_yr);
    assign s_pi = (SW + 1)'(a_im) + (SW + 1)'(r_yi);
    assign s_qr = (SW + 1)'(a_re) - (SW + 1)'(r_yr);
    assign s_qi = (SW + 1)'(a_im) - (SW + 1)'(r_yi);
    assign {h_pr, w_pr} = sat_w(s_pr);
    assign {h_pi, w_pi} = sat_w(s_pi);
    assign {h_qr, w_qr} = sat_w(s_qr);
    assign {h_qi, w_qi} = sat_w(s_qi);

    // divide by n with rounding; shamt is at least one here
    assign rnd_sc = (DW + 1)'(1) << (i_cmd.shamt - SHAMT_W'(1));
    assign sc_re  = ((DW + 1)'(a_re) + rnd_sc) >>> i_cmd.shamt;
    assign sc_im  = ((DW + 1)'(a_im) + rnd_sc) >>> i_cmd.shamt;

    assign {h32_re, o32_re} = sat_o(a_re);
    assign {h32_im, o32_im} = sat_o(a_im);

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = addr_a;
        wr_data = r_smp;
        case (i_cmd.op)
            OP_WRITE:  wr_data = r_smp;
            OP_WR_P:   wr_data = {w_pr, w_pi};
            OP_WR_Q: begin
                wr_addr = addr_b;
                wr_data = {w_qr, w_qi};
            end
            OP_SWAP_A: wr_data = r_rd_b;
            OP_SWAP_B: begin
                wr_addr = addr_b;
                wr_data = r_rd_a;
            end
            OP_SCALE:  wr_data = {sc_re[DW-1:0], sc_im[DW-1:0]};
            default:   wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_smp <= {DW'(i_re_in), DW'(i_im_in)};
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        case (i_cmd.op)
            OP_FETCH: begin
                r_rd_a <= r_mem[addr_a];
                r_rd_b <= r_mem[addr_b];
                r_tw_c <= rom_cos[tw_idx];
                r_tw_s <= i_cmd.inv ? -rom_sin[tw_idx] : rom_sin[tw_idx];
            end
            OP_MUL: begin
                r_p_rr <= b_re * r_tw_c;
                r_p_ii <= b_im * r_tw_s;
                r_p_ri <= b_im * r_tw_c;
                r_p_ir <= b_re * r_tw_s;
            end
            OP_SUM: begin
                r_yr <= d_re >>> F;
                r_yi <= d_im >>> F;
            end
            OP_OUT: begin
                r_out_re  <= o32_re;
                r_out_im  <= o32_im;
                r_out_sat <= r_sticky | h32_re | h32_im;
            end
            OP_DONE: begin
                r_out_re  <= '0;
                r_out_im  <= '0;
                r_out_sat <= r_sticky;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sticky <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_CLEAR: r_sticky <= 1'b0;
                OP_WR_P:  r_sticky <= r_sticky | h_pr | h_pi;
                OP_WR_Q:  r_sticky <= r_sticky | h_qr | h_qi;
                OP_OUT:   r_sticky <= r_sticky | h32_re | h32_im;
                default: ;
            endcase
        end
    end

    assign o_re_out    = r_out_re;
    assign o_im_out    = r_out_im;
    assign o_saturated = r_out_sat;

endmodule

/* bench/tb_top.sv */
// Self-checking bench for radix2_complex_fft: sample writes, transform runs, bin reads.
// Holds a fixed-point FFT predictor in a scoreboard class; random gaps and stalls.
// Depends on r2fft_pkg, the r2fft channel interfaces and the block itself.
module tb_top;
    import r2fft_pkg::*;

    localparam int POINTS = 1024;
    localparam int MAX_L = 10;
    localparam int TW_F = 17;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam longint WORD_HI = 64'sd549755813887;
    localparam longint WORD_LO = -64'sd549755813888;

    typedef struct {
        logic signed [OW-1:0] re;
        logic signed [OW-1:0] im;
        bit sat;
    } t_bin;

    class fft_scoreboard;
        longint mem_re[POINTS];
        longint mem_im[POINTS];
        longint cos_rom[POINTS/2];
        longint sin_rom[POINTS/2];
        bit sticky;
        bit inverse;
        int log2_size;
        t_bin pending_bins[$];
        int errors;

        function new();
            longint unsigned term, x;
            longint c, s;
            int kk;
            sticky = 0;
            inverse = 0;
            log2_size = 10;
            errors = 0;
            for (int k = 0; k < POINTS/2; k++) begin
                kk = (k <= POINTS/4) ? k : POINTS/2 - k;
                x = (longint'(kk) * 64'd6746518852) / POINTS;
                term = 64'd1073741824;
                c = 64'sd1073741824;
                s = 0;
                // Taylor series in Q30, each term truncated
                for (int n = 1; n <= 18; n++) begin
                    term = ((term * x) >> 30) / n;
                    case (n % 4)
                        1: s += term;
                        2: c -= term;
                        3: s -= term;
                        default: c += term;
                    endcase
                end
                cos_rom[k] = (k <= POINTS/4) ? to_q17(c) : -to_q17(c);
                sin_rom[k] = to_q17(s);
            end
        endfunction

        function longint to_q17(longint acc);
            longint mag, r;
            mag = acc < 0 ? -acc : acc;
            r = (mag + (64'sd1 << (29 - TW_F))) >> (30 - TW_F);
            if (r > (64'sd1 << TW_F) - 1) r = (64'sd1 << TW_F) - 1;
            return acc < 0 ? -r : r;
        endfunction

        function longint round_sra(longint v, int s);
            if (s == 0) return v;
            return (v + (64'sd1 << (s - 1))) >>> s;
        endfunction

        function longint clip40(longint v);
            if (v > WORD_HI) begin sticky = 1; return WORD_HI; end
            if (v < WORD_LO) begin sticky = 1; return WORD_LO; end
            return v;
        endfunction

        function logic signed [OW-1:0] clip32(longint v);
            if (v > 64'sd2147483647) begin sticky = 1; return 32'sh7fffffff; end
            if (v < -64'sd2147483648) begin sticky = 1; return 32'sh80000000; end
            return v[OW-1:0];
        endfunction

        function void transform();
            int L, n, r, stride, p, q, t;
            longint wr, wi, br, bi, yr, yi, ar, ai, tmp;
            L = log2_size > MAX_L ? MAX_L : log2_size;
            n = 1 << L;
            sticky = 0;
            for (int i = 0; i < n; i++) begin
                r = 0;
                for (int b = 0; b < L; b++) r |= ((i >> b) & 1) << (L - 1 - b);
                if (i < r) begin
                    tmp = mem_re[i]; mem_re[i] = mem_re[r]; mem_re[r] = tmp;
                    tmp = mem_im[i]; mem_im[i] = mem_im[r]; mem_im[r] = tmp;
                end
            end
            for (int h = 1; h < n; h <<= 1) begin
                stride = POINTS / (2 * h);
                for (int j = 0; j < n; j += 2 * h) begin
                    for (int k = 0; k < h; k++) begin
                        p = j + k;
                        q = j + k + h;
                        t = k * stride;
                        wr = cos_rom[t];
                        wi = inverse ? -sin_rom[t] : sin_rom[t];
                        br = mem_re[q];
                        bi = mem_im[q];
                        yr = round_sra(wr * br - wi * bi, TW_F);
                        yi = round_sra(wr * bi + wi * br, TW_F);
                        ar = mem_re[p];
                        ai = mem_im[p];
                        mem_re[p] = clip40(ar + yr);
                        mem_im[p] = clip40(ai + yi);
                        mem_re[q] = clip40(ar - yr);
                        mem_im[q] = clip40(ai - yi);
                    end
                end
            end
            if (inverse) begin
                for (int i = 0; i < n; i++) begin
                    mem_re[i] = round_sra(mem_re[i], L);
                    mem_im[i] = round_sra(mem_im[i], L);
                end
            end
        endfunction

        function void note_request(logic [FUNC_W-1:0] func, int idx,
                                   logic signed [23:0] re, logic signed [23:0] im);
            t_bin b;
            case (func)
                FUNC_WRITE: begin
                    mem_re[idx] = longint'(re);
                    mem_im[idx] = longint'(im);
                end
                FUNC_RUN: begin
                    transform();
                    b.re = 0;
                    b.im = 0;
                    b.sat = sticky;
                    pending_bins.push_back(b);
                end
                FUNC_READ: begin
                    b.re = clip32(mem_re[idx]);
                    b.im = clip32(mem_im[idx]);
                    b.sat = sticky;
                    pending_bins.push_back(b);
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic signed [OW-1:0] re, logic signed [OW-1:0] im,
                                   logic sat);
            t_bin b;
            if (pending_bins.size() == 0) begin
                $error("unexpected result re_out=%0d im_out=%0d", re, im);
                errors++;
                return;
            end
            b = pending_bins.pop_front();
            if (re !== b.re) begin
                $error("re_out expected %0d actual %0d", b.re, re);
                errors++;
            end
            if (im !== b.im) begin
                $error("im_out expected %0d actual %0d", b.im, im);
                errors++;
            end
            if (sat !== b.sat) begin
                $error("saturated expected %0d actual %0d", b.sat, sat);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;

    r2fft_in_if #(.SB(24)) in_if();
    r2fft_out_if out_if();
    r2fft_cfg_if cfg_if();

    radix2_complex_fft i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if),
        .i_cfg  (cfg_if)
    );

    fft_scoreboard sb = new();
    bit written[POINTS];
    bit quiet = 0;
    int requests_in = 0;
    int items_sent = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit held = 0;

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    initial begin
        in_if.valid = 0;
        in_if.func = FUNC_WRITE;
        in_if.index = 0;
        in_if.re_in = 0;
        in_if.im_in = 0;
        cfg_if.valid = 0;
        cfg_if.index = REG_INVERSE;
        cfg_if.data = 0;
        out_if.ready = 0;
    end

    function int pick_gap();
        return quiet ? 0 : $urandom_range(0, 8);
    endfunction

    // monitors: requests first, so a prediction is in place before any result
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) begin
            sb.note_request(in_if.func, in_if.index, in_if.re_in, in_if.im_in);
            requests_in++;
        end
        if (i_rst_n && out_if.valid && out_if.ready) begin
            sb.check_result(out_if.re_out, out_if.im_out, out_if.saturated);
            stall_left = pick_gap();
        end
        if (i_rst_n && cfg_if.valid && cfg_if.ready) begin
            if (cfg_if.index == REG_INVERSE) sb.inverse = cfg_if.data[0];
            else sb.log2_size = cfg_if.data;
        end
    end

    // result side: per-result stalls, plus one long hold so the block backs up
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 0;
        end else begin
            if (!held && requests_in >= 300) begin
                held = 1;
                hold_left = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 0;
            end else begin
                out_if.ready <= 1;
            end
        end
    end

    task automatic send(logic [FUNC_W-1:0] func, int idx,
                        logic signed [23:0] re, logic signed [23:0] im);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            in_if.valid <= 0;
        end
        @(negedge i_clk);
        in_if.valid <= 1;
        in_if.func <= func;
        in_if.index <= INDEX_W'(idx);
        in_if.re_in <= re;
        in_if.im_in <= im;
        do @(posedge i_clk); while (!in_if.ready);
        if (func == FUNC_WRITE) written[idx] = 1;
        items_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        // drain: wait for every result, then cover work that yields none
        @(negedge i_clk);
        in_if.valid <= 0;
        while (sb.pending_bins.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
        cfg_if.valid <= 1;
        cfg_if.index <= idx;
        cfg_if.data <= CFG_DATA_W'(value);
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 0;
    endtask

    function logic signed [23:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return 24'sh7fffff;
            1: return 24'sh800000;
            2: return $urandom_range(0, 1) ? 24'sh000000 : 24'shffffff;
            3, 4: return 24'($urandom());
            default: return $signed(24'($urandom_range(0, 511))) - 24'sd256;
        endcase
    endfunction

    task automatic run_size(int lg);
        int n;
        n = 1 << (lg > MAX_L ? MAX_L : lg);
        // a run reads every point below n, so all of them must be written
        for (int i = 0; i < n; i++)
            if (!written[i]) send(FUNC_WRITE, i, pick_sample(), pick_sample());
        send(FUNC_RUN, $urandom_range(0, POINTS - 1), pick_sample(), pick_sample());
    endtask

    int size_plan[] = '{1, 3, 2, 5, 0, 4, 6, 15, 1, 7, 2, 10, 3, 8, 4, 11, 9, 1, 5, 2,
                        6, 3, 4, 12, 2};

    initial begin
        int lg, idx, sel, phase;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: extremes, every function, unused code, out-of-size index, zero size
        write_reg(REG_LOG2, 2);
        write_reg(REG_INVERSE, 0);
        send(FUNC_WRITE, 0, 24'sh7fffff, 24'sh800000);
        send(FUNC_WRITE, 1, 24'sh800000, 24'sh7fffff);
        send(FUNC_WRITE, 2, 24'shffffff, 24'sh000000);
        send(FUNC_WRITE, 3, 24'sh000000, 24'shffffff);
        send(FUNC_WRITE, POINTS - 1, 24'sh555555, 24'shaaaaaa);
        send(FUNC_UNUSED, 0, 24'sh123456, 24'sh654321);
        send(FUNC_READ, POINTS - 1, 0, 0);
        send(FUNC_READ, 0, 0, 0);
        send(FUNC_RUN, 0, 0, 0);
        for (int i = 0; i < 4; i++) send(FUNC_READ, i, 0, 0);
        send(FUNC_READ, POINTS - 1, 0, 0);
        write_reg(REG_INVERSE, 1);
        send(FUNC_RUN, 0, 0, 0);
        send(FUNC_READ, 0, 0, 0);
        send(FUNC_READ, 3, 0, 0);
        write_reg(REG_LOG2, 0);
        send(FUNC_RUN, 0, 0, 0);
        send(FUNC_READ, 0, 0, 0);
        send(FUNC_READ, 1, 0, 0);

        phase = 0;
        while (items_sent < 1150) begin
            lg = size_plan[phase % size_plan.size()];
            quiet = (phase % 4 == 3);
            write_reg(REG_LOG2, lg);
            write_reg(REG_INVERSE, $urandom_range(0, 1));
            repeat (55) begin
                sel = $urandom_range(0, 99);
                // mostly below twice the run size, sometimes anywhere in the index field
                idx = $urandom_range(0, 4) == 0 ? $urandom_range(0, POINTS - 1)
                                                : $urandom_range(0, (2 << lg) - 1) % POINTS;
                if (sel < 8) run_size(lg);
                else if (sel < 10) send(FUNC_UNUSED, idx, pick_sample(), pick_sample());
                else if (sel < 45 && written[idx]) send(FUNC_READ, idx, 0, 0);
                else send(FUNC_WRITE, idx, pick_sample(), pick_sample());
            end
            // repeated runs without rewrites push values into saturation
            run_size(lg);
            run_size(lg);
            for (int i = 0; i < 4; i++) begin
                idx = $urandom_range(0, POINTS - 1);
                if (written[idx]) send(FUNC_READ, idx, 0, 0);
            end
            phase++;
        end

        @(negedge i_clk);
        in_if.valid <= 0;
        while (sb.pending_bins.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    initial begin
        #(8 * 4_000_000);
        $display("FAILURE");
        $finish;
    end
endmodule

/* radix2_complex_fft.f */
hdl/r2fft_pkg.sv
hdl/r2fft_ifs.sv
hdl/r2fft_ctrl.sv
hdl/r2fft_dp.sv
hdl/radix2_complex_fft.sv
bench/tb_top.sv
